### hdl/dlp_pkg.sv
// ----------------------------------------------------------------------------
// dlp_pkg
// shared types and constants for the disparity label to point pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package dlp_pkg;

    localparam int COORD_BITS     = 12;
    localparam int COEF_FRAC_BITS = 40;
    localparam int COEF_W         = 48;
    localparam int COEF_HALF      = COEF_W / 2;
    localparam int COEF_DEPTH     = 20;
    localparam int COEF_IDX_W     = 5;
    localparam int MAT_COLS       = 5;
    localparam int MAT_ROWS       = 4;
    localparam int LABEL_W        = 8;
    localparam int COLOR_W        = 8;
    localparam int UNIT_W         = 16;
    localparam int COUNT_W        = 9;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 16;
    localparam int DISP_FRAC      = 17;
    localparam int DISP_W         = 30;
    localparam int PROJ_W         = 64;
    localparam int DELTA_W        = 80;
    localparam int Z_W            = 32;
    localparam int Z_FRAC         = 16;
    localparam int QUO_W          = 32;

    localparam logic [UNIT_W-1:0]    UNIT_RESET  = 16'd1311;
    localparam logic [COUNT_W-1:0]   COUNT_RESET = 9'd75;
    localparam logic [CFG_IDX_W-1:0] CFG_LABEL_UNIT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LABEL_COUNT = 4'd1;

    localparam logic [Z_W-1:0] Z_POS_SAT   = 32'h7FFF_FFFF;
    localparam logic [Z_W-1:0] Z_NEG_SAT   = 32'h8000_0000;
    localparam logic [Z_W-1:0] Z_LOW_CODE  = 32'd6554;
    localparam logic [Z_W-1:0] Z_HIGH_CODE = 32'd131072;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_COEF  = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type                  req_type;
        logic [COEF_IDX_W-1:0]      coef_index;
        logic signed [COEF_W-1:0]   coef_value;
        logic [COORD_BITS-1:0]      pixel_row;
        logic [COORD_BITS-1:0]      pixel_col;
        logic [LABEL_W-1:0]         disp_label;
        logic [COLOR_W-1:0]         blue_in;
        logic [COLOR_W-1:0]         green_in;
        logic [COLOR_W-1:0]         red_in;
    } t_in_req;

    typedef struct packed {
        logic signed [Z_W-1:0]      depth_z;
        logic signed [Z_W-1:0]      pos_x;
        logic signed [Z_W-1:0]      pos_y;
        logic                       in_range;
        logic                       zero_denominator;
        logic [COORD_BITS-1:0]      out_row;
        logic [COORD_BITS-1:0]      out_col;
        logic [COLOR_W-1:0]         blue_out;
        logic [COLOR_W-1:0]         green_out;
        logic [COLOR_W-1:0]         red_out;
    } t_out_res;

    typedef struct packed {
        logic [COORD_BITS-1:0]      row;
        logic [COORD_BITS-1:0]      col;
        logic [COLOR_W-1:0]         blue;
        logic [COLOR_W-1:0]         green;
        logic [COLOR_W-1:0]         red;
    } t_side;

    typedef struct packed {
        logic signed [PROJ_W-1:0]   base_x;
        logic signed [PROJ_W-1:0]   base_y;
        logic signed [PROJ_W:0]     diff_x;
        logic signed [PROJ_W:0]     diff_y;
    } t_geo;

    typedef struct packed {
        logic signed [Z_W-1:0]      z;
        logic                       zden;
    } t_depth;

    typedef struct packed {
        logic                       neg;
        logic                       zden;
        logic                       dst_neg;
        logic                       ovf;
    } t_div_ctl;

endpackage

`default_nettype wire

### hdl/dlp_front.sv
// ----------------------------------------------------------------------------
// dlp_front
// coefficient table, view projections and the two disparity deltas
// ----------------------------------------------------------------------------
`default_nettype none

module dlp_front import dlp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  t_in_req                    i_req,
    input  logic [UNIT_W-1:0]          i_label_unit,
    input  logic [COUNT_W-1:0]         i_label_count,
    output logic                       o_valid,
    output logic signed [DELTA_W-1:0]  o_dst,
    output logic signed [DELTA_W-1:0]  o_duv,
    output t_geo                       o_geo,
    output t_side                      o_side
);

    localparam int PROD_W = COEF_W + COORD_BITS + 1;
    localparam int BASE_W = COEF_W + 5;
    localparam int U7_W   = UNIT_W + 3;
    localparam int DIFF_W = COUNT_W + 2;
    localparam int DMUL_W = U7_W + 1 + DIFF_W;
    localparam int A_W    = COEF_W + 3 + DISP_FRAC;
    localparam int LO_W   = COEF_HALF + 1 + DISP_W;
    localparam int HI_W   = COEF_HALF + DISP_W;

    // stage 0
    logic                      r_f0_valid;
    t_in_req                   r_f0_req;
    logic signed [COEF_W-1:0]  r_coef [COEF_DEPTH];

    // stage 1
    logic                      r_f1_valid;
    logic signed [PROD_W-1:0]  r_p_row [MAT_ROWS];
    logic signed [PROD_W-1:0]  r_p_col [MAT_ROWS];
    logic signed [BASE_W-1:0]  r_base  [MAT_ROWS];
    logic signed [DISP_W-1:0]  r_disp;
    logic signed [COEF_W-1:0]  r_c11, r_c13, r_c31, r_c33;
    t_side                     r_f1_side;

    logic signed [PROD_W-1:0]  n_p_row [MAT_ROWS];
    logic signed [PROD_W-1:0]  n_p_col [MAT_ROWS];
    logic signed [BASE_W-1:0]  n_base  [MAT_ROWS];
    logic [U7_W-1:0]           n_unit7;
    logic signed [DIFF_W-1:0]  n_diff;
    logic signed [DMUL_W-1:0]  n_dmul;

    // stage 2
    logic                      r_f2_valid;
    logic signed [PROJ_W-1:0]  r_o [MAT_ROWS];
    logic signed [A_W-1:0]     r_a1, r_a3;
    logic signed [LO_W-1:0]    r_lo1, r_lo3;
    logic signed [HI_W-1:0]    r_hi1, r_hi3;
    t_side                     r_f2_side;

    logic signed [PROJ_W-1:0]  n_o [MAT_ROWS];
    logic signed [A_W-1:0]     n_a1, n_a3;
    logic signed [LO_W-1:0]    n_lo1, n_lo3;
    logic signed [HI_W-1:0]    n_hi1, n_hi3;

    // stage 3
    logic                      r_f3_valid;
    logic signed [DELTA_W-1:0] r_dst, r_duv;
    t_geo                      r_geo;
    t_side                     r_f3_side;

    logic signed [DELTA_W-1:0] n_dst, n_duv;
    t_geo                      n_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_valid <= 1'b0;
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
            r_f3_valid <= 1'b0;
        end else if (i_en) begin
            r_f0_valid <= i_valid;
            r_f1_valid <= r_f0_valid && (r_f0_req.req_type == REQ_PIXEL);
            r_f2_valid <= r_f1_valid;
            r_f3_valid <= r_f2_valid;
        end
    end

    // table write at the same depth as the pixel reads keeps request order
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f0_req <= i_req;
            if (r_f0_valid && (r_f0_req.req_type == REQ_COEF) &&
                (r_f0_req.coef_index < COEF_IDX_W'(COEF_DEPTH))) begin
                r_coef[r_f0_req.coef_index] <= r_f0_req.coef_value;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < MAT_ROWS; r++) begin
            n_p_row[r] = $signed({1'b0, r_f0_req.pixel_row}) * r_coef[r*MAT_COLS+2];
            n_p_col[r] = $signed({1'b0, r_f0_req.pixel_col}) * r_coef[r*MAT_COLS+3];
            n_base[r]  = (BASE_W'(r_coef[r*MAT_COLS]) <<< 3)
                       + (BASE_W'(r_coef[r*MAT_COLS+1]) <<< 3)
                       + BASE_W'(r_coef[r*MAT_COLS+4]);
        end
        n_unit7 = {i_label_unit, 3'b000} - {3'b000, i_label_unit};
        n_diff  = $signed({2'b00, r_f0_req.disp_label, 1'b0})
                - $signed({2'b00, i_label_count});
        n_dmul  = $signed({1'b0, n_unit7}) * n_diff;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_row        <= n_p_row;
            r_p_col        <= n_p_col;
            r_base         <= n_base;
            r_disp         <= n_dmul[DISP_W-1:0];
            r_c11          <= r_coef[MAT_COLS+1];
            r_c13          <= r_coef[MAT_COLS+3];
            r_c31          <= r_coef[3*MAT_COLS+1];
            r_c33          <= r_coef[3*MAT_COLS+3];
            r_f1_side.row   <= r_f0_req.pixel_row;
            r_f1_side.col   <= r_f0_req.pixel_col;
            r_f1_side.blue  <= r_f0_req.blue_in;
            r_f1_side.green <= r_f0_req.green_in;
            r_f1_side.red   <= r_f0_req.red_in;
        end
    end

    always_comb begin
        for (int r = 0; r < MAT_ROWS; r++) begin
            n_o[r] = PROJ_W'(r_p_row[r]) + PROJ_W'(r_p_col[r]) + PROJ_W'(r_base[r]);
        end
        // seven times the coefficient, aligned to the disparity fraction
        n_a1  = (A_W'(r_c11) <<< (DISP_FRAC + 3)) - (A_W'(r_c11) <<< DISP_FRAC);
        n_a3  = (A_W'(r_c31) <<< (DISP_FRAC + 3)) - (A_W'(r_c31) <<< DISP_FRAC);
        n_lo1 = $signed({1'b0, r_c13[COEF_HALF-1:0]}) * r_disp;
        n_hi1 = $signed(r_c13[COEF_W-1:COEF_HALF]) * r_disp;
        n_lo3 = $signed({1'b0, r_c33[COEF_HALF-1:0]}) * r_disp;
        n_hi3 = $signed(r_c33[COEF_W-1:COEF_HALF]) * r_disp;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o       <= n_o;
            r_a1      <= n_a1;
            r_a3      <= n_a3;
            r_lo1     <= n_lo1;
            r_lo3     <= n_lo3;
            r_hi1     <= n_hi1;
            r_hi3     <= n_hi3;
            r_f2_side <= r_f1_side;
        end
    end

    always_comb begin
        n_dst = DELTA_W'(r_a1) + (DELTA_W'(r_hi1) <<< COEF_HALF) + DELTA_W'(r_lo1);
        n_duv = DELTA_W'(r_a3) + (DELTA_W'(r_hi3) <<< COEF_HALF) + DELTA_W'(r_lo3);
        n_geo.base_x = r_o[0];
        n_geo.base_y = r_o[1];
        n_geo.diff_x = (PROJ_W+1)'(r_o[0]) - (PROJ_W+1)'(r_o[2]);
        n_geo.diff_y = (PROJ_W+1)'(r_o[1]) - (PROJ_W+1)'(r_o[3]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dst     <= n_dst;
            r_duv     <= n_duv;
            r_geo     <= n_geo;
            r_f3_side <= r_f2_side;
        end
    end

    assign o_valid = r_f3_valid;
    assign o_dst   = r_dst;
    assign o_duv   = r_duv;
    assign o_geo   = r_geo;
    assign o_side  = r_f3_side;

endmodule

`default_nettype wire

### hdl/dlp_div.sv
// ----------------------------------------------------------------------------
// dlp_div
// depth quotient: pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module dlp_div import dlp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [DELTA_W-1:0]  i_dst,
    input  logic signed [DELTA_W-1:0]  i_duv,
    input  t_geo                       i_geo,
    input  t_side                      i_side,
    output logic                       o_valid,
    output t_depth                     o_depth,
    output t_geo                       o_geo,
    output t_side                      o_side
);

    localparam int NUM_W = DELTA_W + Z_FRAC + 2;
    localparam int DEN_W = DELTA_W + 1;
    localparam int TOP_W = NUM_W - QUO_W;

    // denominator
    logic                      r_d0_valid;
    logic signed [DELTA_W-1:0] r_d0_num, r_d0_den;
    t_geo                      r_d0_geo;
    t_side                     r_d0_side;

    // magnitudes with the rounding term folded in
    logic                      r_d1_valid;
    logic [NUM_W-1:0]          r_d1_num;
    logic [DEN_W-1:0]          r_d1_den;
    t_div_ctl                  r_d1_ctl;
    t_geo                      r_d1_geo;
    t_side                     r_d1_side;

    logic [DELTA_W-1:0]        n_abs_num, n_abs_den;
    t_div_ctl                  n_d1_ctl;

    // divider stages, index 0 is the overflow check stage
    logic                      r_v    [QUO_W+1];
    logic [DEN_W-1:0]          r_rem  [QUO_W+1];
    logic [QUO_W-1:0]          r_low  [QUO_W+1];
    logic [QUO_W-1:0]          r_quo  [QUO_W+1];
    logic [DEN_W-1:0]          r_den  [QUO_W+1];
    t_div_ctl                  r_ctl  [QUO_W+1];
    t_geo                      r_geo  [QUO_W+1];
    t_side                     r_side [QUO_W+1];

    t_div_ctl                  n_s0_ctl;

    // result
    logic                      r_z_valid;
    t_depth                    r_depth;
    t_geo                      r_z_geo;
    t_side                     r_z_side;
    t_depth                    n_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_valid <= 1'b0;
            r_d1_valid <= 1'b0;
            r_v[0]     <= 1'b0;
            r_z_valid  <= 1'b0;
        end else if (i_en) begin
            r_d0_valid <= i_valid;
            r_d1_valid <= r_d0_valid;
            r_v[0]     <= r_d1_valid;
            r_z_valid  <= r_v[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d0_num  <= i_dst;
            r_d0_den  <= i_dst - i_duv;
            r_d0_geo  <= i_geo;
            r_d0_side <= i_side;
        end
    end

    always_comb begin
        n_abs_num        = r_d0_num[DELTA_W-1] ? DELTA_W'(-r_d0_num) : r_d0_num;
        n_abs_den        = r_d0_den[DELTA_W-1] ? DELTA_W'(-r_d0_den) : r_d0_den;
        n_d1_ctl.neg     = r_d0_num[DELTA_W-1] ^ r_d0_den[DELTA_W-1];
        n_d1_ctl.zden    = (r_d0_den == '0);
        n_d1_ctl.dst_neg = r_d0_num[DELTA_W-1];
        n_d1_ctl.ovf     = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1_num  <= (NUM_W'(n_abs_num) << (Z_FRAC + 1)) + NUM_W'(n_abs_den);
            r_d1_den  <= {n_abs_den, 1'b0};
            r_d1_ctl  <= n_d1_ctl;
            r_d1_geo  <= r_d0_geo;
            r_d1_side <= r_d0_side;
        end
    end

    always_comb begin
        n_s0_ctl     = r_d1_ctl;
        n_s0_ctl.ovf = (NUM_W'(r_d1_num[NUM_W-1:QUO_W]) >= NUM_W'(r_d1_den));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= DEN_W'(r_d1_num[NUM_W-1:QUO_W]);
            r_low[0]  <= r_d1_num[QUO_W-1:0];
            r_quo[0]  <= '0;
            r_den[0]  <= r_d1_den;
            r_ctl[0]  <= n_s0_ctl;
            r_geo[0]  <= r_d1_geo;
            r_side[0] <= r_d1_side;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [DEN_W:0]   w_trial;
        logic             w_take;
        logic [DEN_W:0]   w_diff;

        assign w_trial = {r_rem[k-1], r_low[k-1][QUO_W-1]};
        assign w_diff  = w_trial - {1'b0, r_den[k-1]};
        assign w_take  = (w_trial >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_take ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_low[k]  <= {r_low[k-1][QUO_W-2:0], 1'b0};
                r_quo[k]  <= {r_quo[k-1][QUO_W-2:0], w_take};
                r_den[k]  <= r_den[k-1];
                r_ctl[k]  <= r_ctl[k-1];
                r_geo[k]  <= r_geo[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_comb begin
        n_depth.zden = r_ctl[QUO_W].zden;
        priority if (r_ctl[QUO_W].zden) begin
            n_depth.z = r_ctl[QUO_W].dst_neg ? Z_NEG_SAT : Z_POS_SAT;
        end else if (r_ctl[QUO_W].ovf) begin
            n_depth.z = r_ctl[QUO_W].neg ? Z_NEG_SAT : Z_POS_SAT;
        end else if (r_ctl[QUO_W].neg) begin
            n_depth.z = (r_quo[QUO_W] > Z_NEG_SAT) ? Z_NEG_SAT : (~r_quo[QUO_W] + 1'b1);
        end else begin
            n_depth.z = r_quo[QUO_W][QUO_W-1] ? Z_POS_SAT : r_quo[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_depth  <= n_depth;
            r_z_geo  <= r_geo[QUO_W];
            r_z_side <= r_side[QUO_W];
        end
    end

    assign o_valid = r_z_valid;
    assign o_depth = r_depth;
    assign o_geo   = r_z_geo;
    assign o_side  = r_z_side;

endmodule

`default_nettype wire

### hdl/dlp_pos.sv
// ----------------------------------------------------------------------------
// dlp_pos
// x and y positions from the depth, range flag and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module dlp_pos import dlp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_depth    i_depth,
    input  t_geo      i_geo,
    input  t_side     i_side,
    output logic      o_valid,
    output t_out_res  o_res
);

    localparam int PART_W = Z_W + Z_W + 1;
    localparam int V_W    = PROJ_W + Z_W + 4;

    logic                      r_p0_valid;
    logic signed [PART_W-1:0]  r_xlo, r_xhi, r_ylo, r_yhi;
    logic signed [PROJ_W-1:0]  r_base_x, r_base_y;
    t_depth                    r_depth;
    t_side                     r_p0_side;

    logic                      r_out_valid;
    t_out_res                  r_res;

    logic signed [V_W-1:0]     n_vx, n_vy;
    t_out_res                  n_res;

    function automatic logic [Z_W-1:0] f_sat(input logic signed [V_W-1:0] v);
        logic [V_W-COEF_FRAC_BITS-Z_W:0] top;
        begin
            top = v[V_W-1:COEF_FRAC_BITS+Z_W-1];
            if ((top == '0) || (top == '1)) begin
                f_sat = v[COEF_FRAC_BITS+Z_W-1:COEF_FRAC_BITS];
            end else begin
                f_sat = v[V_W-1] ? Z_NEG_SAT : Z_POS_SAT;
            end
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_p0_valid  <= i_valid;
            r_out_valid <= r_p0_valid;
        end
    end

    // depth times difference, split in two halves of the difference
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xlo     <= i_depth.z * $signed({1'b0, i_geo.diff_x[Z_W-1:0]});
            r_xhi     <= i_depth.z * $signed(i_geo.diff_x[PROJ_W:Z_W]);
            r_ylo     <= i_depth.z * $signed({1'b0, i_geo.diff_y[Z_W-1:0]});
            r_yhi     <= i_depth.z * $signed(i_geo.diff_y[PROJ_W:Z_W]);
            r_base_x  <= i_geo.base_x;
            r_base_y  <= i_geo.base_y;
            r_depth   <= i_depth;
            r_p0_side <= i_side;
        end
    end

    always_comb begin
        n_vx = (V_W'(r_base_x) <<< Z_FRAC)
             - ((V_W'(r_xhi) <<< Z_W) + V_W'(r_xlo))
             + (V_W'(1) <<< (COEF_FRAC_BITS - 1));
        n_vy = (V_W'(r_base_y) <<< Z_FRAC)
             - ((V_W'(r_yhi) <<< Z_W) + V_W'(r_ylo))
             + (V_W'(1) <<< (COEF_FRAC_BITS - 1));
        n_res.depth_z          = r_depth.z;
        n_res.pos_x            = f_sat(n_vx);
        n_res.pos_y            = f_sat(n_vy);
        n_res.in_range         = !r_depth.zden && !r_depth.z[Z_W-1] &&
                                 (r_depth.z >= Z_LOW_CODE) && (r_depth.z < Z_HIGH_CODE);
        n_res.zero_denominator = r_depth.zden;
        n_res.out_row          = r_p0_side.row;
        n_res.out_col          = r_p0_side.col;
        n_res.blue_out         = r_p0_side.blue;
        n_res.green_out        = r_p0_side.green;
        n_res.red_out          = r_p0_side.red;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

### hdl/disparity_label_to_point.sv
// an accepted pixel request passes front, divider and position to the output
// throughput: one request per cycle unless stalled; set by the 32 stage divider
// the whole pipeline holds while a result waits on the output; nothing is dropped
// coefficient writes give no result and take effect in request order
// reset is synchronous, active low; clears valid bits and loads label registers
// ----------------------------------------------------------------------------
// disparity_label_to_point
// turns a pixel with a disparity label into a depth and an x/y position
// ----------------------------------------------------------------------------
`default_nettype none

module disparity_label_to_point import dlp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_req                i_in_req,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_res               o_out_res,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [UNIT_W-1:0]     r_label_unit;
    logic [COUNT_W-1:0]    r_label_count;

    logic                  w_en;
    logic                  w_front_valid;
    logic signed [DELTA_W-1:0] w_dst, w_duv;
    t_geo                  w_front_geo;
    t_side                 w_front_side;
    logic                  w_div_valid;
    t_depth                w_depth;
    t_geo                  w_div_geo;
    t_side                 w_div_side;
    logic                  w_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_unit  <= UNIT_RESET;
            r_label_count <= COUNT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_LABEL_UNIT) begin
                r_label_unit <= i_cfg_data[UNIT_W-1:0];
            end
            if (i_cfg_index == CFG_LABEL_COUNT) begin
                r_label_count <= i_cfg_data[COUNT_W-1:0];
            end
        end
    end

    assign w_en        = !w_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = w_out_valid;

    dlp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_in_valid),
        .i_req         (i_in_req),
        .i_label_unit  (r_label_unit),
        .i_label_count (r_label_count),
        .o_valid       (w_front_valid),
        .o_dst         (w_dst),
        .o_duv         (w_duv),
        .o_geo         (w_front_geo),
        .o_side        (w_front_side)
    );

    dlp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_valid),
        .i_dst   (w_dst),
        .i_duv   (w_duv),
        .i_geo   (w_front_geo),
        .i_side  (w_front_side),
        .o_valid (w_div_valid),
        .o_depth (w_depth),
        .o_geo   (w_div_geo),
        .o_side  (w_div_side)
    );

    dlp_pos u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_valid),
        .i_depth (w_depth),
        .i_geo   (w_div_geo),
        .i_side  (w_div_side),
        .o_valid (w_out_valid),
        .o_res   (o_out_res)
    );

endmodule

`default_nettype wire
